>>> sv/array_element_address_defines.svh
// Assertion macros for the array element address unit
`ifndef ARRAY_ELEMENT_ADDRESS_DEFINES_SVH
`define ARRAY_ELEMENT_ADDRESS_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define AEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define AEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/aea_pkg.sv
// Package: sizes, opcodes and table entry types for the array element address unit
`default_nettype none

package aea_pkg;

  localparam int MAX_ARRAYS = 16;
  localparam int MAX_DIMS   = 8;
  localparam int ID_W       = 4;
  localparam int POS_W      = 3;
  localparam int BND_AW     = ID_W + POS_W;

  localparam logic [1:0] OP_HDR   = 2'd0;
  localparam logic [1:0] OP_BND   = 2'd1;
  localparam logic [1:0] OP_INDEX = 2'd2;

  typedef struct packed {
    logic [31:0] base;
    logic [15:0] elsize;
    logic [3:0]  dims;
  } hdr_t;

  typedef struct packed {
    logic signed [15:0] lower;
    logic signed [15:0] upper;
  } bnd_t;

endpackage

`default_nettype wire

>>> sv/array_element_address.sv
// Top level: row-major array element address unit with descriptor tables
//
//  channel | dir | fields
//  --------+-----+--------------------------------------------------------------
//  s_*     | in  | tuser op; tdata id, base, elsize, dim count, dim pos, bounds, index
//  m_*     | out | tdata address, queried array (one request per finished query)
//
// Header and bounds writes are stored when accepted. An index component runs in steps:
// accept (header read), bounds read, index/length prep, two 32x18 multiply steps
// for offset*length. The last component adds two 16x32 steps for elsize*offset.
// All steps run in sequence through one state machine. Reset (rst, synchronous)
// clears the query counter, offset and output valid; both tables hold garbage
// until written. A finished address waits in the output register; a new item is
// accepted meanwhile, and the unit only waits when a second address is ready
// before the first was taken.
`default_nettype none

`include "array_element_address_defines.svh"

module array_element_address (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  // [3:0] array_id, [35:4] base_address, [51:36] element_size,
  // [55:52] dim_count, [58:56] dim_pos, [74:59] lower_bound,
  // [90:75] upper_bound, [106:91] index_value, [111:107] zero
  input  wire logic [111:0] s_tdata,
  // [1:0] op
  input  wire logic [1:0]   s_tuser,
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  // [63:0] address, [67:64] queried_array, [71:68] zero
  output      logic [71:0]  m_tdata
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HDR  = 7'b0000010,
    S_BND  = 7'b0000100,
    S_MLO  = 7'b0001000,
    S_MHI  = 7'b0010000,
    S_ELO  = 7'b0100000,
    S_EHI  = 7'b1000000
  } state_t;

  // input fields
  logic [1:0]                 in_op;
  logic [aea_pkg::ID_W-1:0]   in_id;
  logic [31:0]                in_base;
  logic [15:0]                in_elsize;
  logic [3:0]                 in_dims;
  logic [aea_pkg::POS_W-1:0]  in_pos;
  logic signed [15:0]         in_lower;
  logic signed [15:0]         in_upper;
  logic signed [15:0]         in_index;

  assign in_op     = s_tuser;
  assign in_id     = s_tdata[3:0];
  assign in_base   = s_tdata[35:4];
  assign in_elsize = s_tdata[51:36];
  assign in_dims   = s_tdata[55:52];
  assign in_pos    = s_tdata[58:56];
  assign in_lower  = s_tdata[74:59];
  assign in_upper  = s_tdata[90:75];
  assign in_index  = s_tdata[106:91];

  // descriptor tables
  aea_pkg::hdr_t hdr_mem [aea_pkg::MAX_ARRAYS];
  aea_pkg::bnd_t bnd_mem [aea_pkg::MAX_ARRAYS * aea_pkg::MAX_DIMS];
  aea_pkg::hdr_t hdr_rd;
  aea_pkg::bnd_t bnd_rd;

  state_t                     state;
  logic [63:0]                offset;
  logic [63:0]                acc;
  logic [3:0]                 count;
  logic [aea_pkg::ID_W-1:0]   cur_array;
  logic signed [15:0]         index_r;
  logic [3:0]                 dims_eff;
  logic signed [17:0]         len_r;
  logic signed [16:0]         en_r;
  logic                       last_r;
  logic [63:0]                out_addr;
  logic [aea_pkg::ID_W-1:0]   out_id;

  logic                       in_fire;
  logic                       query_fire;
  logic [aea_pkg::ID_W-1:0]   rd_id;
  logic [3:0]                 dims_now;
  logic [aea_pkg::POS_W-1:0]  rd_pos;
  logic signed [50:0]         p_lo;
  logic signed [50:0]         p_hi;
  logic [47:0]                e_lo;
  logic [47:0]                e_hi;
  logic [4:0]                 count_inc;
  logic                       out_free;

  function automatic logic [47:0] elsize_mul(input logic [15:0] a, input logic [31:0] b);
    elsize_mul = {32'b0, a} * {16'b0, b};
  endfunction

  assign s_tready   = (state == S_IDLE);
  assign in_fire    = s_tvalid && s_tready;
  assign query_fire = in_fire && (in_op == aea_pkg::OP_INDEX);
  assign rd_id      = (count == 4'd0) ? in_id : cur_array;
  assign out_free   = !m_tvalid || m_tready;
  assign count_inc  = {1'b0, count} + 5'd1;

  // dimension count: zero counts as one, larger than the table saturates
  always_comb begin
    if (hdr_rd.dims == 4'd0) begin
      dims_now = 4'd1;
    end else if (hdr_rd.dims > 4'(aea_pkg::MAX_DIMS)) begin
      dims_now = 4'(aea_pkg::MAX_DIMS);
    end else begin
      dims_now = hdr_rd.dims;
    end
  end

  // bounds row: current component, clamped to the last dimension if the
  // header shrank during the query
  assign rd_pos = (count >= dims_now) ? aea_pkg::POS_W'(dims_now - 4'd1)
                                      : aea_pkg::POS_W'(count);

  // offset * length split over the two halves of the offset (mod 2^64)
  assign p_lo = $signed({1'b0, offset[31:0]}) * len_r;
  assign p_hi = $signed({1'b0, offset[63:32]}) * len_r;
  // element size * offset, same split
  assign e_lo = elsize_mul(hdr_rd.elsize, offset[31:0]);
  assign e_hi = elsize_mul(hdr_rd.elsize, offset[63:32]);

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (in_fire && (in_op == aea_pkg::OP_HDR)) begin
      hdr_mem[in_id] <= '{base: in_base, elsize: in_elsize, dims: in_dims};
    end
    if (in_fire && (in_op == aea_pkg::OP_BND)) begin
      bnd_mem[{in_id, in_pos}] <= '{lower: in_lower, upper: in_upper};
    end
    if (query_fire) begin
      hdr_rd <= hdr_mem[rd_id];
    end
    if (state == S_HDR) begin
      bnd_rd <= bnd_mem[{cur_array, rd_pos}];
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (query_fire) begin
          index_r <= in_index;
        end
      end
      S_HDR: begin
        dims_eff <= dims_now;
      end
      S_BND: begin
        len_r  <= 18'({{2{bnd_rd.upper[15]}}, bnd_rd.upper})
                - 18'({{2{bnd_rd.lower[15]}}, bnd_rd.lower}) + 18'sd1;
        en_r   <= 17'({index_r[15], index_r}) - 17'({bnd_rd.lower[15], bnd_rd.lower});
        last_r <= (count_inc >= {1'b0, dims_eff});
      end
      S_MLO: begin
        acc <= {{13{p_lo[50]}}, p_lo} + {{47{en_r[16]}}, en_r};
      end
      S_ELO: begin
        acc <= {16'b0, e_lo} + {32'b0, hdr_rd.base};
      end
      S_EHI: begin
        if (out_free) begin
          out_addr <= acc + {e_hi[31:0], 32'b0};
          out_id   <= cur_array;
        end
      end
      default: begin
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      offset    <= '0;
      count     <= '0;
      cur_array <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // new address loads the output register, else a taken one clears it
      if ((state == S_EHI) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (query_fire) begin
            cur_array <= rd_id;
            state     <= S_HDR;
          end
        end
        S_HDR: state <= S_BND;
        S_BND: state <= S_MLO;
        S_MLO: state <= S_MHI;
        S_MHI: begin
          offset <= acc + {p_hi[31:0], 32'b0};
          if (last_r) begin
            state <= S_ELO;
          end else begin
            count <= count_inc[3:0];
            state <= S_IDLE;
          end
        end
        S_ELO: state <= S_EHI;
        S_EHI: begin
          if (out_free) begin
            offset   <= '0;
            count    <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'b0, out_id, out_addr};

  // checks
  `AEA_ASSERT_NOW(a_count_range, 1'b1, count < 4'(aea_pkg::MAX_DIMS), "count past last dim")
  `AEA_ASSERT_NOW(a_offset_clear, (state == S_IDLE) && (count == 4'd0), ~|offset, "stale offset")
  `AEA_ASSERT_NOW(a_result_src, $rose(m_tvalid), $past(state == S_EHI), "stray result")
  `AEA_ASSERT_NEXT(a_query_start, query_fire, state == S_HDR, "query did not start")

endmodule

`default_nettype wire
